### design/max_subarray_endpoint_range_query_defines.svh
// Assertion macros for the max-subarray range query block.
// Used by design/max_subarray_endpoint_range_query.sv; needs clk and rst_n in scope.
`ifndef MAX_SUBARRAY_ENDPOINT_RANGE_QUERY_DEFINES_SVH
`define MAX_SUBARRAY_ENDPOINT_RANGE_QUERY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSQ_ASSERT_SAME(lbl, ante, cons, msg)
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/msq_pkg.sv
// Shared types, constants and node merge function for the range query block.
// No dependencies.
`timescale 1ns / 1ps
package msq_pkg;
  localparam int MAX_LENGTH   = 1024;
  localparam int LEN_W        = 11;
  localparam int VALUE_BITS   = 16;
  localparam int SUM_BITS     = 27;
  localparam int ACC_W        = 32;
  localparam int ADDR_W       = $clog2(2 * MAX_LENGTH);
  localparam int LEAF_BASE    = MAX_LENGTH - 1;
  localparam int NODE_W       = 4 * SUM_BITS;
  localparam logic signed [ACC_W-1:0] NEG_IDENTITY = 32'sd1000000000;

  typedef struct packed {
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] pre;
    logic signed [ACC_W-1:0] suf;
    logic signed [ACC_W-1:0] inner;
  } agg_t;

  function automatic agg_t agg_identity();
    agg_t e;
    e.total = '0;
    e.pre   = -NEG_IDENTITY;
    e.suf   = -NEG_IDENTITY;
    e.inner = -NEG_IDENTITY;
    return e;
  endfunction

  function automatic logic signed [ACC_W-1:0] smax(logic signed [ACC_W-1:0] a,
                                                   logic signed [ACC_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic agg_t agg_merge(agg_t a, agg_t b);
    agg_t c;
    c.total = a.total + b.total;
    c.pre   = smax(a.pre, a.total + b.pre);
    c.suf   = smax(b.suf, b.total + a.suf);
    c.inner = smax(smax(a.inner, b.inner), a.suf + b.pre);
    return c;
  endfunction

  function automatic agg_t node_unpack(logic [NODE_W-1:0] d);
    agg_t a;
    a.total = ACC_W'($signed(d[4*SUM_BITS-1:3*SUM_BITS]));
    a.pre   = ACC_W'($signed(d[3*SUM_BITS-1:2*SUM_BITS]));
    a.suf   = ACC_W'($signed(d[2*SUM_BITS-1:SUM_BITS]));
    a.inner = ACC_W'($signed(d[SUM_BITS-1:0]));
    return a;
  endfunction

  function automatic logic [NODE_W-1:0] node_pack(agg_t a);
    return {a.total[SUM_BITS-1:0], a.pre[SUM_BITS-1:0],
            a.suf[SUM_BITS-1:0], a.inner[SUM_BITS-1:0]};
  endfunction
endpackage

### design/max_subarray_endpoint_range_query.sv
// Max-subarray query with endpoint limits over a segment tree in one node RAM.
// Loads: busy stays low. Queries: a check, then up to five tree walks (per level up to
// two node reads and a shift) and a final result step; the first query after a load or
// length write rebuilds all 1023 inner nodes, each from reads of both children and a write.
// Bad queries strobe via S_CHECK and out_valid_r; out_valid lasts one cycle. Sync active-low
// reset: length 1, tree stale, RAM not cleared. Uses msq_pkg, msq_ram, the defines header.
`timescale 1ns / 1ps
`include "max_subarray_endpoint_range_query_defines.svh"
module max_subarray_endpoint_range_query
  import msq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [LEN_W-1:0]            in_position,
  input  logic signed [VALUE_BITS-1:0] in_element_value,
  input  logic [LEN_W-1:0]            in_start_low,
  input  logic [LEN_W-1:0]            in_start_high,
  input  logic [LEN_W-1:0]            in_end_low,
  input  logic [LEN_W-1:0]            in_end_high,
  output logic                        out_valid,
  output logic signed [SUM_BITS-1:0]  out_best_sum,
  output logic                        out_bad_query,
  input  logic                        cfg_we,
  input  logic [LEN_W-1:0]            cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_B_RD0, S_B_RD1, S_B_WR,
    S_W_INIT, S_W_CHK, S_W_RL, S_W_RR, S_FIN
  } state_t;

  localparam int KW = ADDR_W - 1;
  localparam int LW = ADDR_W + 1;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  tree_ok_r, tree_ok_nxt;
  logic [LEN_W-1:0]      x1_r, y1_r, x2_r, y2_r;
  logic [LEN_W-1:0]      x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [LW-1:0]         l_r, l_nxt, r_r, r_nxt;
  logic [2:0]            wi_r, wi_nxt;
  agg_t                  left_r, left_nxt;
  agg_t                  resl_r, resl_nxt, resr_r, resr_nxt;
  agg_t                  w_r [5];
  agg_t                  w_nxt [5];
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SUM_BITS-1:0] out_sum_r, out_sum_nxt;
  logic                  out_bad_r, out_bad_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [NODE_W-1:0]     ram_wdata, ram_rdata;
  agg_t                  rd_agg, leaf_agg;
  logic                  disj;
  logic [2:0]            last_wi;
  logic [LW-1:0]         ql, qr;
  logic                  accept;
  logic                  query_ok;
  logic signed [ACC_W-1:0] best;

  msq_ram #(.WIDTH(NODE_W), .DEPTH(2 * MAX_LENGTH)) u_nodes (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign rd_agg = node_unpack(ram_rdata);
  assign disj   = (y1_r < x2_r);
  assign last_wi = disj ? 3'd2 : 3'd4;

  always_comb begin
    leaf_agg.total = ACC_W'(in_element_value);
    leaf_agg.pre   = ACC_W'(in_element_value);
    leaf_agg.suf   = ACC_W'(in_element_value);
    leaf_agg.inner = ACC_W'(in_element_value);
  end

  assign query_ok = (x1_r != '0) && (x1_r <= y1_r) && (y1_r <= len_r) &&
                    (x2_r <= y2_r) && (y2_r <= len_r) && (x1_r <= x2_r) &&
                    (y1_r <= y2_r);

  // walk bounds in positions; disjoint: starts, gap, ends
  // overlapping: head, both, tail, ends, starts
  always_comb begin
    ql = {1'b0, x1_r};
    qr = {1'b0, y1_r};
    if (disj) begin
      case (wi_r)
        3'd1: begin
          ql = {1'b0, y1_r} + LW'(1);
          qr = {1'b0, x2_r} - LW'(1);
        end
        3'd2: begin
          ql = {1'b0, x2_r};
          qr = {1'b0, y2_r};
        end
        default: begin
          ql = {1'b0, x1_r};
          qr = {1'b0, y1_r};
        end
      endcase
    end else begin
      case (wi_r)
        3'd0: begin
          ql = {1'b0, x1_r};
          qr = {1'b0, x2_r} - LW'(1);
        end
        3'd1: begin
          ql = {1'b0, x2_r};
          qr = {1'b0, y1_r};
        end
        3'd2: begin
          ql = {1'b0, y1_r} + LW'(1);
          qr = {1'b0, y2_r};
        end
        3'd3: begin
          ql = {1'b0, x2_r};
          qr = {1'b0, y2_r};
        end
        default: begin
          ql = {1'b0, x1_r};
          qr = {1'b0, y1_r};
        end
      endcase
    end
  end

  always_comb begin
    if (disj) begin
      best = w_r[0].suf + w_r[1].total + w_r[2].pre;
    end else begin
      best = smax(smax(w_r[0].suf + w_r[3].pre, w_r[4].suf + w_r[2].pre), w_r[1].inner);
    end
  end

  always_comb begin
    ram_raddr = {k_r, 1'b0};
    case (state_r)
      S_B_RD0: ram_raddr = {k_r, 1'b0};
      S_B_RD1: ram_raddr = {k_r, 1'b1};
      S_W_CHK: ram_raddr = l_r[0] ? l_r[ADDR_W-1:0] : r_r[ADDR_W-1:0];
      default: ram_raddr = {k_r, 1'b0};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    tree_ok_nxt   = tree_ok_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    wi_nxt        = wi_r;
    left_nxt      = left_r;
    resl_nxt      = resl_r;
    resr_nxt      = resr_r;
    w_nxt         = w_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_waddr     = {1'b0, k_r};
    ram_wdata     = node_pack(agg_merge(left_r, rd_agg));

    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_wdata > LEN_W'(MAX_LENGTH)) begin
        len_nxt = LEN_W'(MAX_LENGTH);
      end else begin
        len_nxt = cfg_wdata;
      end
      tree_ok_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            if ((in_position != '0) && (in_position <= LEN_W'(MAX_LENGTH))) begin
              ram_we      = 1'b1;
              ram_waddr   = ADDR_W'(in_position + LEN_W'(LEAF_BASE));
              ram_wdata   = node_pack(leaf_agg);
              tree_ok_nxt = 1'b0;
            end
          end else begin
            x1_nxt    = in_start_low;
            y1_nxt    = in_start_high;
            x2_nxt    = in_end_low;
            y2_nxt    = in_end_high;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        wi_nxt = '0;
        k_nxt  = KW'(LEAF_BASE);
        if (!query_ok) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = '0;
          out_bad_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!tree_ok_r) begin
          state_nxt = S_B_RD0;
        end else begin
          state_nxt = S_W_INIT;
        end
      end
      S_B_RD0: state_nxt = S_B_RD1;
      S_B_RD1: begin
        left_nxt  = rd_agg;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        ram_we = 1'b1;
        k_nxt  = k_r - KW'(1);
        if (k_r == KW'(1)) begin
          tree_ok_nxt = 1'b1;
          state_nxt   = S_W_INIT;
        end else begin
          state_nxt = S_B_RD0;
        end
      end
      S_W_INIT: begin
        l_nxt     = ql + LW'(LEAF_BASE);
        r_nxt     = qr + LW'(LEAF_BASE);
        resl_nxt  = agg_identity();
        resr_nxt  = agg_identity();
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (l_r > r_r) begin
          w_nxt[wi_r] = agg_merge(resl_r, resr_r);
          wi_nxt      = wi_r + 3'd1;
          state_nxt   = (wi_r == last_wi) ? S_FIN : S_W_INIT;
        end else if (l_r[0]) begin
          state_nxt = S_W_RL;
        end else if (!r_r[0]) begin
          state_nxt = S_W_RR;
        end else begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end
      end
      S_W_RL: begin
        resl_nxt  = agg_merge(resl_r, rd_agg);
        l_nxt     = l_r + LW'(1);
        state_nxt = S_W_CHK;
      end
      S_W_RR: begin
        resr_nxt  = agg_merge(rd_agg, resr_r);
        r_nxt     = r_r - LW'(1);
        state_nxt = S_W_CHK;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = best[SUM_BITS-1:0];
        out_bad_nxt   = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(1);
      tree_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      tree_ok_r   <= tree_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    x2_r      <= x2_nxt;
    y2_r      <= y2_nxt;
    k_r       <= k_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    wi_r      <= wi_nxt;
    left_r    <= left_nxt;
    resl_r    <= resl_nxt;
    resr_r    <= resr_nxt;
    w_r       <= w_nxt;
    out_sum_r <= out_sum_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_best_sum  = out_sum_r;
  assign out_bad_query = out_bad_r;

  `MSQ_ASSERT_NEXT(a_query_goes_busy, accept && in_action, busy, "query transfer did not start work")
  `MSQ_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "two results for one query")
  `MSQ_ASSERT_SAME(a_bad_is_zero, out_valid && out_bad_query, out_best_sum == '0, "bad query with nonzero sum")
  `MSQ_ASSERT_SAME(a_build_stale, state_r == S_B_RD0 || state_r == S_B_RD1, !tree_ok_r, "rebuild while tree current")
endmodule

### design/msq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
